// File: src/joystick_jog_position_integrator_assert.svh
// Assertion macros used by the jog integrator checker.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef JOYSTICK_JOG_POSITION_INTEGRATOR_ASSERT_SVH
`define JOYSTICK_JOG_POSITION_INTEGRATOR_ASSERT_SVH

// same-cycle implication
`define JJPI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define JJPI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/jjpi_pkg.sv
// Shared types, constants and saturation helpers for the jog position integrator.
// No dependencies.
package jjpi_pkg;

    // setpoint storage width
    localparam int POS_W = 32;
    // candidate width: setpoint plus six increments, with room for the home offset
    localparam int CW    = ((POS_W > 31) ? POS_W : 31) + 3;
    // width of an offset from the home point
    localparam int DW    = CW + 1;

    localparam int OUT_W  = 32;
    localparam int RD_W   = 16;
    localparam int STEP_W = 24;
    localparam int CT_W   = 14;
    localparam int HOME_W = 32;
    localparam int RAD_W  = 63;
    localparam int CFG_DW = 63;
    localparam int CFG_IW = 3;
    localparam int OP_W   = 4;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_CONTROL_TYPES  = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_X_STEP         = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_Y_STEP         = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_Z_STEP         = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_HOME_Z_CENTER  = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_RADIUS_SQUARED = 3'd5;

    // configuration reset values
    localparam logic [CT_W-1:0]          RST_CONTROL_TYPES = '0;
    localparam logic [STEP_W-1:0]        RST_STEP          = 24'd85899;
    localparam logic signed [HOME_W-1:0] RST_HOME_Z        = 32'sd1524713390;
    localparam logic [RAD_W-1:0]         RST_RADIUS_SQ     = 63'd311749974845691422;

    // control type codes
    localparam logic [1:0] CT_NONE   = 2'd0;
    localparam logic [1:0] CT_AXIS   = 2'd1;
    localparam logic [1:0] CT_TRIG   = 2'd2;
    localparam logic [1:0] CT_BUTTON = 2'd3;

    // datapath operations, issued to the shared multiplier in this order
    localparam logic [OP_W-1:0] OP_FWD    = 4'd0;
    localparam logic [OP_W-1:0] OP_BACK   = 4'd1;
    localparam logic [OP_W-1:0] OP_LEFT   = 4'd2;
    localparam logic [OP_W-1:0] OP_RIGHT  = 4'd3;
    localparam logic [OP_W-1:0] OP_UP     = 4'd4;
    localparam logic [OP_W-1:0] OP_DOWN   = 4'd5;
    localparam logic [OP_W-1:0] OP_SQ_X   = 4'd6;
    localparam logic [OP_W-1:0] OP_SQ_Y   = 4'd7;
    localparam logic [OP_W-1:0] OP_SQ_Z   = 4'd8;
    // last product still being accumulated, no new issue
    localparam logic [OP_W-1:0] OP_DRAIN  = 4'd9;

    typedef struct packed {
        logic            load;
        logic            mul_en;
        logic [OP_W-1:0] op;
        logic            fin;
    } t_cmd;

    function automatic logic signed [POS_W-1:0] sat_to_pos(input logic signed [CW-1:0] v);
        if (v[CW-1:POS_W-1] == '0 || v[CW-1:POS_W-1] == '1) begin
            return v[POS_W-1:0];
        end
        return v[CW-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_to_out(input logic signed [CW-1:0] v);
        if (v[CW-1:OUT_W-1] == '0 || v[CW-1:OUT_W-1] == '1) begin
            return v[OUT_W-1:0];
        end
        return v[CW-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    endfunction

    localparam logic signed [CW-1:0]    START_Z_EXT = CW'(32'sd1524713390);
    localparam logic signed [POS_W-1:0] START_Z_POS = sat_to_pos(START_Z_EXT);

endpackage

// File: src/jjpi_in_if.sv
// Input channel: one tick of gamepad readings with valid/ready handshake.
// Stand-alone; widths are those of the readings.
interface jjpi_in_if;
    logic               valid;
    logic               ready;
    logic               joy_valid;
    logic               enable_pressed;
    logic signed [15:0] reset_reading;
    logic signed [15:0] forward_reading;
    logic signed [15:0] backward_reading;
    logic signed [15:0] left_reading;
    logic signed [15:0] right_reading;
    logic signed [15:0] up_reading;
    logic signed [15:0] down_reading;

    modport source (
        output valid, joy_valid, enable_pressed, reset_reading, forward_reading,
               backward_reading, left_reading, right_reading, up_reading, down_reading,
        input  ready
    );
    modport sink (
        input  valid, joy_valid, enable_pressed, reset_reading, forward_reading,
               backward_reading, left_reading, right_reading, up_reading, down_reading,
        output ready
    );
endinterface

// File: src/jjpi_out_if.sv
// Output channel: committed setpoint and commit flag with valid/ready handshake.
// Stand-alone.
interface jjpi_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               move_committed;

    modport source (
        output valid, pos_x, pos_y, pos_z, move_committed,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, move_committed,
        output ready
    );
endinterface

// File: src/jjpi_ctrl.sv
// Sequencer for the jog integrator: handshakes and the multiply/accumulate schedule.
// Depends on jjpi_pkg.
module jjpi_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_joy_valid,
    input  logic          i_enable,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output jjpi_pkg::t_cmd o_cmd
);
    import jjpi_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]      r_state, n_state;
    logic [OP_W-1:0] r_cnt, n_cnt;
    logic            r_out_valid, n_out_valid;
    t_cmd            w_cmd;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        w_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_cnt      = OP_FWD;
                    // a tick without joystick data is dropped here
                    if (i_joy_valid) begin
                        n_state = i_enable ? S_RUN : S_FIN;
                    end
                end
            end
            S_RUN: begin
                w_cmd.op     = r_cnt;
                w_cmd.mul_en = (r_cnt != OP_DRAIN);
                if (r_cnt == OP_DRAIN) begin
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FIN: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (w_cmd.fin) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= OP_FWD;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule

// File: src/jjpi_dp.sv
// Datapath: configuration, setpoint, candidate, shared multiplier and boundary test.
// Depends on jjpi_pkg; sequenced by jjpi_ctrl.
module jjpi_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  jjpi_pkg::t_cmd                  i_cmd,
    input  logic                            i_cfg_wr_en,
    input  logic [jjpi_pkg::CFG_IW-1:0]     i_cfg_index,
    input  logic [jjpi_pkg::CFG_DW-1:0]     i_cfg_wdata,
    input  logic                            i_enable,
    input  logic signed [jjpi_pkg::RD_W-1:0] i_reset_reading,
    input  logic signed [jjpi_pkg::RD_W-1:0] i_forward_reading,
    input  logic signed [jjpi_pkg::RD_W-1:0] i_backward_reading,
    input  logic signed [jjpi_pkg::RD_W-1:0] i_left_reading,
    input  logic signed [jjpi_pkg::RD_W-1:0] i_right_reading,
    input  logic signed [jjpi_pkg::RD_W-1:0] i_up_reading,
    input  logic signed [jjpi_pkg::RD_W-1:0] i_down_reading,
    output logic signed [jjpi_pkg::OUT_W-1:0] o_pos_x,
    output logic signed [jjpi_pkg::OUT_W-1:0] o_pos_y,
    output logic signed [jjpi_pkg::OUT_W-1:0] o_pos_z,
    output logic                            o_move_committed
);
    import jjpi_pkg::*;

    // configuration
    logic [CT_W-1:0]          r_ctl_types;
    logic [STEP_W-1:0]        r_x_step, r_y_step, r_z_step;
    logic signed [HOME_W-1:0] r_home_z;
    logic [RAD_W-1:0]         r_rad_sq;

    // committed setpoint
    logic signed [POS_W-1:0]  r_sp_x, r_sp_y, r_sp_z;

    // per-tick working state
    logic signed [RD_W-1:0]   r_rd_fwd, r_rd_back, r_rd_left, r_rd_right, r_rd_up, r_rd_down;
    logic signed [CW-1:0]     r_cx, r_cy, r_cz;
    logic                     r_en;
    logic [63:0]              r_sum;
    logic                     r_fail;
    logic [63:0]              r_prod;
    logic                     r_acc_en;
    logic [OP_W-1:0]          r_acc_op;
    logic                     r_acc_sh16;

    // outputs
    logic signed [OUT_W-1:0]  r_pos_x, r_pos_y, r_pos_z;
    logic                     r_move;

    // operand selection
    logic signed [RD_W-1:0]   w_rd;
    logic signed [RD_W:0]     w_rd17;
    logic signed [RD_W:0]     w_rd_neg;
    logic [1:0]               w_type;
    logic [STEP_W-1:0]        w_step;
    logic                     w_pos_half;
    logic                     w_is_sq;
    logic signed [DW-1:0]     w_d;
    logic [DW-1:0]            w_dmag;
    logic                     w_big;
    logic [RD_W:0]            w_b;
    logic                     w_sh16;
    logic [31:0]              w_mul_a, w_mul_b;

    // accumulate
    logic [41:0]              w_rnd;
    logic [26:0]              w_inc;
    logic signed [CW-1:0]     w_inc_s;
    logic [64:0]              w_sq_sum;
    logic                     w_acc_sq;

    // finish
    logic                     w_rst_pressed;
    logic                     w_commit;
    logic signed [POS_W-1:0]  w_nsp_x, w_nsp_y, w_nsp_z;

    always_comb begin
        w_rd       = '0;
        w_type     = CT_NONE;
        w_step     = '0;
        w_pos_half = 1'b0;
        w_is_sq    = 1'b0;
        w_d        = '0;
        unique case (i_cmd.op)
            OP_FWD: begin
                w_rd = r_rd_fwd;   w_type = r_ctl_types[3:2];   w_step = r_x_step;
                w_pos_half = 1'b1;
            end
            OP_BACK: begin
                w_rd = r_rd_back;  w_type = r_ctl_types[5:4];   w_step = r_x_step;
            end
            OP_LEFT: begin
                w_rd = r_rd_left;  w_type = r_ctl_types[7:6];   w_step = r_y_step;
                w_pos_half = 1'b1;
            end
            OP_RIGHT: begin
                w_rd = r_rd_right; w_type = r_ctl_types[9:8];   w_step = r_y_step;
            end
            OP_UP: begin
                w_rd = r_rd_up;    w_type = r_ctl_types[11:10]; w_step = r_z_step;
                w_pos_half = 1'b1;
            end
            OP_DOWN: begin
                w_rd = r_rd_down;  w_type = r_ctl_types[13:12]; w_step = r_z_step;
            end
            OP_SQ_X: begin
                w_is_sq = 1'b1; w_d = DW'(r_cx);
            end
            OP_SQ_Y: begin
                w_is_sq = 1'b1; w_d = DW'(r_cy);
            end
            OP_SQ_Z: begin
                w_is_sq = 1'b1; w_d = DW'(r_cz) - DW'(r_home_z);
            end
            default: ;
        endcase
    end

    assign w_rd17   = (RD_W+1)'(w_rd);
    assign w_rd_neg = -w_rd17;

    // deflection factor, Q15 except for triggers which are Q16
    always_comb begin
        w_b    = '0;
        w_sh16 = 1'b0;
        unique case (w_type)
            CT_AXIS: begin
                if (w_pos_half) begin
                    w_b = (w_rd > 0) ? w_rd17 : '0;
                end else begin
                    w_b = (w_rd < 0) ? w_rd_neg : '0;
                end
            end
            CT_TRIG: begin
                w_b    = (RD_W+1)'(18'sd32768 - 18'(w_rd));
                w_sh16 = 1'b1;
            end
            // full step: s * 2^15 >> 15
            CT_BUTTON: w_b = (w_rd != 0) ? (RD_W+1)'(32768) : '0;
            CT_NONE:   w_b = '0;
            default:   w_b = '0;
        endcase
    end

    assign w_dmag  = w_d[DW-1] ? DW'(-w_d) : DW'(w_d);
    assign w_big   = |w_dmag[DW-1:32];
    assign w_mul_a = w_is_sq ? w_dmag[31:0] : 32'(w_step);
    assign w_mul_b = w_is_sq ? w_dmag[31:0] : 32'(w_b);

    // round half up, then drop the fraction
    assign w_rnd    = 42'(r_prod[40:0]) + (r_acc_sh16 ? 42'd32768 : 42'd16384);
    assign w_inc    = r_acc_sh16 ? 27'(w_rnd[41:16]) : w_rnd[41:15];
    assign w_inc_s  = $signed(CW'(w_inc));
    assign w_sq_sum = 65'(r_sum) + 65'(r_prod);
    assign w_acc_sq = (r_acc_op == OP_SQ_X) || (r_acc_op == OP_SQ_Y) ||
                      (r_acc_op == OP_SQ_Z);

    assign w_rst_pressed = (r_ctl_types[1:0] != CT_NONE) && (i_reset_reading != 0);

    assign w_commit = r_en && !r_fail && (r_sum < 64'(r_rad_sq));
    assign w_nsp_x  = w_commit ? sat_to_pos(r_cx) : r_sp_x;
    assign w_nsp_y  = w_commit ? sat_to_pos(r_cy) : r_sp_y;
    assign w_nsp_z  = w_commit ? sat_to_pos(r_cz) : r_sp_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_types <= RST_CONTROL_TYPES;
            r_x_step    <= RST_STEP;
            r_y_step    <= RST_STEP;
            r_z_step    <= RST_STEP;
            r_home_z    <= RST_HOME_Z;
            r_rad_sq    <= RST_RADIUS_SQ;
            r_sp_x      <= '0;
            r_sp_y      <= '0;
            r_sp_z      <= START_Z_POS;
            r_acc_en    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_CONTROL_TYPES:  r_ctl_types <= i_cfg_wdata[CT_W-1:0];
                    CFG_X_STEP:         r_x_step    <= i_cfg_wdata[STEP_W-1:0];
                    CFG_Y_STEP:         r_y_step    <= i_cfg_wdata[STEP_W-1:0];
                    CFG_Z_STEP:         r_z_step    <= i_cfg_wdata[STEP_W-1:0];
                    CFG_HOME_Z_CENTER:  r_home_z    <= $signed(i_cfg_wdata[HOME_W-1:0]);
                    CFG_RADIUS_SQUARED: r_rad_sq    <= i_cfg_wdata[RAD_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.fin) begin
                r_sp_x <= w_nsp_x;
                r_sp_y <= w_nsp_y;
                r_sp_z <= w_nsp_z;
            end
            r_acc_en <= i_cmd.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd_fwd   <= i_forward_reading;
            r_rd_back  <= i_backward_reading;
            r_rd_left  <= i_left_reading;
            r_rd_right <= i_right_reading;
            r_rd_up    <= i_up_reading;
            r_rd_down  <= i_down_reading;
            r_en       <= i_enable;
            r_sum      <= '0;
            r_fail     <= 1'b0;
            if (w_rst_pressed) begin
                r_cx <= '0;
                r_cy <= '0;
                r_cz <= CW'(START_Z_POS);
            end else begin
                r_cx <= CW'(r_sp_x);
                r_cy <= CW'(r_sp_y);
                r_cz <= CW'(r_sp_z);
            end
        end

        if (i_cmd.mul_en) begin
            r_prod     <= 64'(w_mul_a) * 64'(w_mul_b);
            r_acc_op   <= i_cmd.op;
            r_acc_sh16 <= w_sh16;
        end

        // an offset of 2^32 or more, or a sum that overflows, fails the test
        if ((i_cmd.mul_en && w_is_sq && w_big) || (r_acc_en && w_acc_sq && w_sq_sum[64])) begin
            r_fail <= 1'b1;
        end

        if (r_acc_en) begin
            unique case (r_acc_op)
                OP_FWD:   r_cx  <= r_cx + w_inc_s;
                OP_BACK:  r_cx  <= r_cx - w_inc_s;
                OP_LEFT:  r_cy  <= r_cy - w_inc_s;
                OP_RIGHT: r_cy  <= r_cy + w_inc_s;
                OP_UP:    r_cz  <= r_cz + w_inc_s;
                OP_DOWN:  r_cz  <= r_cz - w_inc_s;
                OP_SQ_X, OP_SQ_Y, OP_SQ_Z: r_sum <= w_sq_sum[63:0];
                default: ;
            endcase
        end

        if (i_cmd.fin) begin
            r_pos_x <= sat_to_out(CW'(w_nsp_x));
            r_pos_y <= sat_to_out(CW'(w_nsp_y));
            r_pos_z <= sat_to_out(CW'(w_nsp_z));
            r_move  <= w_commit;
        end
    end

    assign o_pos_x          = r_pos_x;
    assign o_pos_y          = r_pos_y;
    assign o_pos_z          = r_pos_z;
    assign o_move_committed = r_move;

endmodule

// File: src/joystick_jog_position_integrator.sv
// Jog position integrator: with enable held, a tick is accepted, then runs on the shared
// 32x32 multiplier (six increments and three squares, pipelined one behind the other,
// then a drain step), then commits; no new tick is accepted before the commit.
// With enable released a tick skips the multiplier; without joystick data it is dropped.
// Synchronous active-low reset loads default configuration, the start setpoint, idles.
module joystick_jog_position_integrator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    jjpi_in_if.sink                       i_in,
    jjpi_out_if.source                    o_out,
    input  logic                          i_cfg_wr_en,
    input  logic [jjpi_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [jjpi_pkg::CFG_DW-1:0]   i_cfg_wdata
);
    import jjpi_pkg::*;

    t_cmd w_cmd;
    logic w_in_ready;
    logic w_out_valid;

    jjpi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_joy_valid (i_in.joy_valid),
        .i_enable    (i_in.enable_pressed),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd)
    );

    jjpi_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_enable           (i_in.enable_pressed),
        .i_reset_reading    (i_in.reset_reading),
        .i_forward_reading  (i_in.forward_reading),
        .i_backward_reading (i_in.backward_reading),
        .i_left_reading     (i_in.left_reading),
        .i_right_reading    (i_in.right_reading),
        .i_up_reading       (i_in.up_reading),
        .i_down_reading     (i_in.down_reading),
        .o_pos_x            (o_out.pos_x),
        .o_pos_y            (o_out.pos_y),
        .o_pos_z            (o_out.pos_z),
        .o_move_committed   (o_out.move_committed)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

endmodule

// File: src/jjpi_checker.sv
// Port-level checks for the jog position integrator, attached by bind.
// Depends on joystick_jog_position_integrator_assert.svh.
`include "joystick_jog_position_integrator_assert.svh"

module jjpi_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_joy_valid,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] i_pos_x,
    input logic signed [31:0] i_pos_y,
    input logic signed [31:0] i_pos_z,
    input logic               i_move
);

    `JJPI_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")

    `JJPI_ASSERT_NXT(a_out_stable, i_out_valid && !i_out_ready, $stable(i_pos_x) && $stable(i_pos_y) && $stable(i_pos_z) && $stable(i_move), "stalled result changed")

    `JJPI_ASSERT_NXT(a_busy_after_tick, i_in_valid && i_in_ready && i_joy_valid, !i_in_ready, "input taken while a tick is in progress")

    `JJPI_ASSERT_IMP(a_result_from_busy, $rose(i_out_valid), !$past(i_in_ready), "result appeared without a tick in progress")

endmodule

bind joystick_jog_position_integrator jjpi_checker u_jjpi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_joy_valid (i_in.joy_valid),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_pos_x     (o_out.pos_x),
    .i_pos_y     (o_out.pos_y),
    .i_pos_z     (o_out.pos_z),
    .i_move      (o_out.move_committed)
);
